FILE: src/i2cms_pkg.sv
// Package for the I2C master bit sequencer: item structs, command codes,
// the per-command step counts and the step phase tables.
// No dependencies.
`default_nettype none

package i2cms_pkg;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_WRITE = 3'd3,
		OP_READ  = 3'd4,
		OP_SACK  = 3'd5,
		OP_RACK  = 3'd6
	} op_t;

	localparam int unsigned STEP_W = 5;
	localparam int unsigned TICK_W = 16;
	localparam logic [TICK_W-1:0] STEP_LEN_RST = 16'd10;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] write_data;
		logic       ack_value;
		logic       sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_byte;
		logic       ack_seen;
		logic       rejected;
	} out_item_t;

	// step mod 3
	localparam logic [1:0] PH_TBL [0:31] = '{
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
		2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
		2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
		2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
	};

	// (step / 3) mod 8, the bit group of a write
	localparam logic [2:0] GRP_TBL [0:31] = '{
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
		3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5,
		3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd7, 3'd7, 3'd7,
		3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2
	};

	function automatic logic [STEP_W-1:0] seq_len(input op_t op);
		logic [STEP_W-1:0] n;
		unique case (op)
			OP_START: n = 5'd4;
			OP_STOP:  n = 5'd3;
			OP_WRITE: n = 5'd24;
			OP_READ:  n = 5'd25;
			OP_SACK:  n = 5'd3;
			OP_RACK:  n = 5'd4;
			default:  n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

FILE: src/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: input register, one tick of sequencer
// logic, result register. Uses i2cms_pkg.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------
//  in      | in        | in_valid / in_stall   | i2cms_pkg::in_item_t
//  out     | out       | out_valid / out_stall | i2cms_pkg::out_item_t
//  cfg     | in        | cfg_valid / cfg_ready | cfg_data, step length
//
// One item per clock sustained while out is not stalled; an item's result is computed
// from the input register by the single pass of sequencer logic between the two
// registers and loaded into the result register, which offers it. A stall on out
// holds the result register and, once the input register is also full, raises
// in_stall. Reset puts the lines released, the sequencer idle and the step length at
// ten ticks.
`default_nettype none

module i2c_master_bit_sequencer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire i2cms_pkg::in_item_t  in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output i2cms_pkg::out_item_t      out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [15:0]          cfg_data
);

	localparam int unsigned SW = i2cms_pkg::STEP_W;
	localparam int unsigned TW = i2cms_pkg::TICK_W;

	i2cms_pkg::in_item_t  in_data_s1;
	logic                 valid_s1;
	logic                 adv;
	logic                 out_valid_q;
	i2cms_pkg::out_item_t out_data_q;

	logic [TW-1:0]        step_len_q;

	i2cms_pkg::op_t       cur_q, n_cur;
	logic [SW-1:0]        step_q, n_step;
	logic [TW-1:0]        tick_q, n_tick;
	logic [7:0]           shift_q, n_shift;
	logic                 scl_q, n_scl;
	logic                 sda_q, n_sda;
	logic [7:0]           rd_q, n_rd;
	logic                 ack_q, n_ack;
	logic                 done, rej, cmd, do_en;
	logic [TW-1:0]        len;
	logic [1:0]           ph;
	logic [2:0]           grp;
	i2cms_pkg::out_item_t res;

	assign cfg_ready = 1'b1;
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		len    = (step_len_q == '0) ? TW'(1) : step_len_q;
		cmd    = (in_data_s1.action >= i2cms_pkg::OP_START) &&
		         (in_data_s1.action <= i2cms_pkg::OP_RACK);
		n_cur   = cur_q;
		n_step  = step_q;
		n_tick  = tick_q;
		n_shift = shift_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_rd    = rd_q;
		n_ack   = ack_q;
		done    = 1'b0;
		rej     = 1'b0;
		do_en   = 1'b0;
		ph      = 2'd0;
		grp     = 3'd0;

		if (cur_q != i2cms_pkg::OP_NONE) begin
			rej = cmd;
			if (({1'b0, tick_q} + (TW+1)'(1)) >= {1'b0, len}) begin
				n_step = step_q + SW'(1);
				n_tick = '0;
				if (n_step >= i2cms_pkg::seq_len(cur_q)) begin
					if (cur_q == i2cms_pkg::OP_READ)
						n_rd = shift_q;
					n_cur  = i2cms_pkg::OP_NONE;
					n_step = '0;
					done   = 1'b1;
				end else begin
					do_en = 1'b1;
				end
			end else begin
				n_tick = tick_q + TW'(1);
			end
		end else if (cmd) begin
			n_cur  = i2cms_pkg::op_t'(in_data_s1.action);
			n_step = '0;
			n_tick = '0;
			if (in_data_s1.action == i2cms_pkg::OP_WRITE)
				n_shift = in_data_s1.write_data;
			else if (in_data_s1.action == i2cms_pkg::OP_SACK)
				n_shift = {7'd0, in_data_s1.ack_value};
			else
				n_shift = '0;
			do_en = 1'b1;
		end

		// pin step performed on this tick
		if (do_en) begin
			unique case (n_cur)
				i2cms_pkg::OP_START: begin
					if (n_step == SW'(0))      n_sda = 1'b1;
					else if (n_step == SW'(1)) n_scl = 1'b1;
					else if (n_step == SW'(2)) n_sda = 1'b0;
					else                       n_scl = 1'b0;
				end
				i2cms_pkg::OP_STOP: begin
					if (n_step == SW'(0))      n_sda = 1'b0;
					else if (n_step == SW'(1)) n_scl = 1'b1;
					else                       n_sda = 1'b1;
				end
				i2cms_pkg::OP_WRITE: begin
					ph  = i2cms_pkg::PH_TBL[n_step];
					grp = i2cms_pkg::GRP_TBL[n_step];
					if (ph == 2'd0)      n_sda = n_shift[3'd7 - grp];
					else if (ph == 2'd1) n_scl = 1'b1;
					else                 n_scl = 1'b0;
				end
				i2cms_pkg::OP_READ: begin
					if (n_step == SW'(0)) begin
						n_sda = 1'b1;
					end else begin
						ph = i2cms_pkg::PH_TBL[n_step - SW'(1)];
						if (ph == 2'd0)      n_scl = 1'b1;
						else if (ph == 2'd1) n_shift = {n_shift[6:0], in_data_s1.sda_in};
						else                 n_scl = 1'b0;
					end
				end
				i2cms_pkg::OP_SACK: begin
					if (n_step == SW'(0))      n_sda = n_shift[0];
					else if (n_step == SW'(1)) n_scl = 1'b1;
					else                       n_scl = 1'b0;
				end
				i2cms_pkg::OP_RACK: begin
					if (n_step == SW'(0))      n_sda = 1'b1;
					else if (n_step == SW'(1)) n_scl = 1'b1;
					else if (n_step == SW'(2)) n_ack = in_data_s1.sda_in;
					else                       n_scl = 1'b0;
				end
				default: ;
			endcase
		end

		res.scl_drive = n_scl;
		res.sda_drive = n_sda;
		res.busy_res  = (n_cur != i2cms_pkg::OP_NONE);
		res.done_res  = done;
		res.read_byte = n_rd;
		res.ack_seen  = n_ack;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_len_q  <= i2cms_pkg::STEP_LEN_RST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			cur_q       <= i2cms_pkg::OP_NONE;
			step_q      <= '0;
			tick_q      <= '0;
			shift_q     <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			rd_q        <= '0;
			ack_q       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				step_len_q <= cfg_data;
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (adv) begin
				cur_q   <= n_cur;
				step_q  <= n_step;
				tick_q  <= n_tick;
				shift_q <= n_shift;
				scl_q   <= n_scl;
				sda_q   <= n_sda;
				rd_q    <= n_rd;
				ack_q   <= n_ack;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			in_data_s1 <= in_data;
		if (adv)
			out_data_q <= res;
	end

`ifndef SYNTH
	// reported busy matches the sequencer state after the tick
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (out_data_q.busy_res == (cur_q != i2cms_pkg::OP_NONE)))
		else $error("busy result disagrees with sequencer state");

	// step counter never runs past the end of its sequence
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_q != i2cms_pkg::OP_NONE) |-> (step_q < i2cms_pkg::seq_len(cur_q)))
		else $error("step index beyond sequence length");

	// an idle tick without a command leaves the sequencer idle and quiet
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (cur_q == i2cms_pkg::OP_NONE) && !cmd) |=>
		((cur_q == i2cms_pkg::OP_NONE) && !out_data_q.done_res && !out_data_q.rejected))
		else $error("idle tick changed sequencer state");
`endif

endmodule

`default_nettype wire
